// ----- design/sym3inv_pkg.sv -----
// Package for the symmetric 3x3 inverse core.
// Holds the default data format of the core and the element count; no other dependencies.
`timescale 1ns / 1ps

package sym3inv_pkg;

  // Default word format: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Number of unique elements in a symmetric 3x3 matrix.
  localparam int NUM_ELEM = 6;

endpackage

// ----- design/symmetric_3x3_matrix_inverse_core.sv -----
// Symmetric 3x3 matrix inverse by cofactors, fully pipelined.
// Depends on sym3inv_pkg for the default data format.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one word per
// matrix, the six upper-triangle elements a_00 .. a_22 in signed fixed point
// with FRAC_BITS fraction bits. The output channel (out_valid_o / out_ready_i)
// carries one word per matrix: the six unique inverse elements, each rounded
// to nearest with ties away from zero and saturated, plus the singular and
// saturated flags. A singular matrix returns the identity.
//
// The default format is Q16.16. The pipeline takes one word in every cycle
// unless the receiver holds the output back and every stage is full. The
// depth comes from the long divider: one quotient bit per stage, with
// DATA_WIDTH + 1 stages behind the product, cofactor, partial-product, term,
// determinant, magnitude and scaling stages, and the output stage after them.
//
// Each stage holds its own valid bit. A stage loads whenever it is empty or
// the stage after it moves, so bubbles close up and a stalled receiver only
// backs the pipeline up once every stage is full. Reset clears all valid
// bits; the data registers are not reset.
`timescale 1ns / 1ps

module symmetric_3x3_matrix_inverse_core #(
  parameter int DATA_WIDTH = sym3inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sym3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] a_00_i,
  input  logic signed [DATA_WIDTH-1:0] a_01_i,
  input  logic signed [DATA_WIDTH-1:0] a_02_i,
  input  logic signed [DATA_WIDTH-1:0] a_11_i,
  input  logic signed [DATA_WIDTH-1:0] a_12_i,
  input  logic signed [DATA_WIDTH-1:0] a_22_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] inv_00_o,
  output logic signed [DATA_WIDTH-1:0] inv_01_o,
  output logic signed [DATA_WIDTH-1:0] inv_02_o,
  output logic signed [DATA_WIDTH-1:0] inv_11_o,
  output logic signed [DATA_WIDTH-1:0] inv_12_o,
  output logic signed [DATA_WIDTH-1:0] inv_22_o,
  output logic                         singular_o,
  output logic                         saturated_o
);

  import sym3inv_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;            // product width
  localparam int CW  = 2 * W + 1;        // cofactor width
  localparam int CL  = (CW + 1) / 2;     // low slice of a cofactor
  localparam int CH  = CW - CL;          // high slice of a cofactor
  localparam int TW  = 3 * W + 1;        // determinant term width
  localparam int DW  = 3 * W + 3;        // determinant width
  localparam int XW  = CW + 2 * F + 1;   // scaled numerator width
  localparam int RW  = (XW > DW + W + 2) ? XW : DW + W + 2;
  localparam int QW  = W + 1;            // quotient with one rounding bit
  localparam int NST = W + 9;            // number of pipeline stages
  localparam int SD0 = 7;                // first divider stage
  localparam int SO  = NST - 1;          // output stage

  localparam logic [W-1:0]  ONE_VAL = (F < W - 1) ? (W'(1) << F)
                                                  : {1'b0, {(W-1){1'b1}}};
  localparam logic          ONE_SAT = (F >= W - 1);
  localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(W-1){1'b1}}});
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);

  // Handshake: each stage loads when any stage from it to the output is
  // empty or the receiver takes the output word.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  for (genvar g = 0; g < NST; g++) begin : g_en
    assign en[g] = out_ready_i || !(&v_q[NST-1:g]);
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[SO];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: the twelve products of the cofactors.
  logic signed [PW-1:0] p_q [12];
  logic signed [W-1:0]  a1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q[0]  <= a_11_i * a_22_i;
      p_q[1]  <= a_12_i * a_12_i;
      p_q[2]  <= a_12_i * a_02_i;
      p_q[3]  <= a_01_i * a_22_i;
      p_q[4]  <= a_01_i * a_12_i;
      p_q[5]  <= a_11_i * a_02_i;
      p_q[6]  <= a_00_i * a_22_i;
      p_q[7]  <= a_02_i * a_02_i;
      p_q[8]  <= a_02_i * a_01_i;
      p_q[9]  <= a_00_i * a_12_i;
      p_q[10] <= a_00_i * a_11_i;
      p_q[11] <= a_01_i * a_01_i;
      a1_q[0] <= a_00_i;
      a1_q[1] <= a_01_i;
      a1_q[2] <= a_02_i;
    end
  end

  // Stage 2: cofactors, in the order 00, 01, 02, 11, 12, 22.
  logic signed [CW-1:0] c2_q [NUM_ELEM];
  logic signed [W-1:0]  a2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        c2_q[k] <= CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
      end
      a2_q <= a1_q;
    end
  end

  // Stage 3: first row times its cofactors, split in two partial products.
  logic signed [W+CL:0]   lo_q [3];
  logic signed [W+CH-1:0] hi_q [3];
  logic signed [CW-1:0]   c3_q [NUM_ELEM];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= a2_q[k] * $signed({1'b0, c2_q[k][CL-1:0]});
        hi_q[k] <= a2_q[k] * $signed(c2_q[k][CW-1:CL]);
      end
      c3_q <= c2_q;
    end
  end

  // Stage 4: recombine the partial products into full terms.
  logic signed [TW-1:0] t_q  [3];
  logic signed [CW-1:0] c4_q [NUM_ELEM];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        t_q[k] <= (TW'(hi_q[k]) <<< CL) + TW'(lo_q[k]);
      end
      c4_q <= c3_q;
    end
  end

  // Stage 5: determinant.
  logic signed [DW-1:0] det_q;
  logic signed [CW-1:0] c5_q [NUM_ELEM];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det_q <= DW'(t_q[0]) + DW'(t_q[1]) + DW'(t_q[2]);
      c5_q  <= c4_q;
    end
  end

  // Stage 6: magnitudes, result signs and the singular flag.
  logic [CW-1:0]       cm_q [NUM_ELEM];
  logic [DW-1:0]       dm6_q;
  logic [NUM_ELEM-1:0] neg6_q;
  logic                sing6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        cm_q[k]   <= c5_q[k][CW-1] ? CW'(-c5_q[k]) : CW'(c5_q[k]);
        neg6_q[k] <= c5_q[k][CW-1] ^ det_q[DW-1];
      end
      dm6_q   <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      sing6_q <= (det_q == '0);
    end
  end

  // Divider pipeline. Index 0 is loaded by stage 7 with the scaled
  // numerator and the overflow check; each divider stage settles one
  // quotient bit, most significant first.
  logic [RW-1:0]       dr_q [W+2][NUM_ELEM];
  logic [QW-1:0]       dq_q [W+2][NUM_ELEM];
  logic [DW-1:0]       dd_q [W+2];
  logic [NUM_ELEM-1:0] dn_q [W+2];
  logic [NUM_ELEM-1:0] dv_q [W+2];
  logic                ds_q [W+2];

  logic [RW-1:0] xn [NUM_ELEM];
  logic [RW-1:0] dlim;

  always_comb begin
    dlim = RW'(dm6_q) << (W + 1);
    for (int k = 0; k < NUM_ELEM; k++) begin
      xn[k] = RW'(cm_q[k]) << (2 * F + 1);
    end
  end

  // Stage 7: a quotient of 2^(W+1) or more saturates whatever its sign.
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        dr_q[0][k] <= xn[k];
        dq_q[0][k] <= '0;
        dv_q[0][k] <= (xn[k] >= dlim);
      end
      dd_q[0] <= dm6_q;
      dn_q[0] <= neg6_q;
      ds_q[0] <= sing6_q;
    end
  end

  for (genvar j = 0; j <= W; j++) begin : g_div
    localparam int SH = W - j;
    logic [RW-1:0] dsh;

    assign dsh = RW'(dd_q[j]) << SH;

    always_ff @(posedge clk_i) begin
      if (en[SD0+j]) begin
        for (int k = 0; k < NUM_ELEM; k++) begin
          if (dr_q[j][k] >= dsh) begin
            dr_q[j+1][k] <= dr_q[j][k] - dsh;
            dq_q[j+1][k] <= dq_q[j][k] | (QW'(1) << SH);
          end else begin
            dr_q[j+1][k] <= dr_q[j][k];
            dq_q[j+1][k] <= dq_q[j][k];
          end
        end
        dd_q[j+1] <= dd_q[j];
        dn_q[j+1] <= dn_q[j];
        dv_q[j+1] <= dv_q[j];
        ds_q[j+1] <= ds_q[j];
      end
    end
  end

  // Output stage: round half away from zero, saturate, apply the sign; a singular matrix gives the identity.
  logic [QW:0]         qsum [NUM_ELEM];
  logic [QW-1:0]       qmag [NUM_ELEM];
  logic [QW-1:0]       qlim [NUM_ELEM];
  logic [QW-1:0]       qval [NUM_ELEM];
  logic [NUM_ELEM-1:0] qsat;
  logic [W-1:0]        res_d [NUM_ELEM];
  logic [W-1:0]        inv_q [NUM_ELEM];
  logic                sing_q;
  logic                sat_q;

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      qsum[k] = {1'b0, dq_q[W+1][k]} + (QW+1)'(1);
      qmag[k] = qsum[k][QW:1];
      qlim[k] = dn_q[W+1][k] ? LIM_NEG : LIM_POS;
      qsat[k] = dv_q[W+1][k] || (qmag[k] > qlim[k]);
      qval[k] = qsat[k] ? qlim[k] : qmag[k];
      res_d[k] = dn_q[W+1][k] ? W'(-qval[k]) : qval[k][W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      if (ds_q[W+1]) begin
        inv_q[0] <= ONE_VAL;
        inv_q[1] <= '0;
        inv_q[2] <= '0;
        inv_q[3] <= ONE_VAL;
        inv_q[4] <= '0;
        inv_q[5] <= ONE_VAL;
        sat_q    <= ONE_SAT;
      end else begin
        inv_q <= res_d;
        sat_q <= |qsat;
      end
      sing_q <= ds_q[W+1];
    end
  end

  assign inv_00_o    = inv_q[0];
  assign inv_01_o    = inv_q[1];
  assign inv_02_o    = inv_q[2];
  assign inv_11_o    = inv_q[3];
  assign inv_12_o    = inv_q[4];
  assign inv_22_o    = inv_q[5];
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

  // A singular matrix gives zeros off the diagonal.
  a_sing_offdiag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inv_01_o == '0 && inv_02_o == '0 && inv_12_o == '0)
    else $error("singular result with nonzero off-diagonal element");

  // A singular matrix gives the same value on the whole diagonal.
  a_sing_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inv_00_o == inv_11_o && inv_11_o == inv_22_o)
    else $error("singular result with unequal diagonal");

  // The input side only stalls when the output word is held back.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule
